/* rtl/core/moving_average_lowpass_defines.svh */
// ----------------------------------------------------------------------------
// Moving average low-pass: assertion macros
// Shared concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_LOWPASS_DEFINES_SVH
`define MOVING_AVERAGE_LOWPASS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MAL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("moving average lowpass: assertion failed");
`define MAL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("moving average lowpass: sequence check failed");
`else
`define MAL_ASSERT(label, clk, rst, prop)
`define MAL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* rtl/core/mal_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass package
// Sizes, derived widths and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package mal_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int SAMPLE_W   = 16;
   localparam int WINDOW_W   = 10;

   // ring is stored as rows of LANES samples so row valid bits stay few
   localparam int LANES      = 4;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ROWS       = (RING_DEPTH + LANES - 1) / LANES;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_DATA_W = LANES * SAMPLE_W;

   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int WIN_W      = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = SAMPLE_W + WIN_W;
   localparam int CNT_W      = $clog2(SUM_W + 1);

   localparam int CMP_A      = (WINDOW_W > WIN_W) ? WINDOW_W : WIN_W;
   localparam int CMP_W      = (CMP_A > ROW_W + LANE_W) ? CMP_A : ROW_W + LANE_W;

   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic scan_acc;
      logic rd_old;
      logic write;
      logic div_go;
      logic mod_go;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic stale;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

/* rtl/core/mal_channels.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass channel interfaces
// Valid/ready channels for samples in, averages out and the window register.
// ----------------------------------------------------------------------------
interface mal_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mal_pkg::SAMPLE_W-1:0]  sample;
   logic                                 clear_ring;

   modport source (output valid, output sample, output clear_ring, input ready);
   modport sink   (input valid, input sample, input clear_ring, output ready);
endinterface

interface mal_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mal_pkg::SAMPLE_W-1:0]  filtered_sample;

   modport source (output valid, output filtered_sample, input ready);
   modport sink   (input valid, input filtered_sample, output ready);
endinterface

interface mal_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mal_pkg::WINDOW_W-1:0]         window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

/* rtl/core/mal_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/mal_divider.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mal_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mal_pkg::SUM_W-1:0]   dividend,
   input  logic [mal_pkg::WIN_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [mal_pkg::SUM_W-1:0]   quotient,
   output logic [mal_pkg::WIN_W-1:0]   remainder
);
   logic [mal_pkg::SUM_W-1:0] quo_ff, quo_in;
   logic [mal_pkg::WIN_W-1:0] rem_ff, rem_in;
   logic [mal_pkg::WIN_W-1:0] dvs_ff, dvs_in;
   logic [mal_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [mal_pkg::WIN_W:0]   shifted;
   logic [mal_pkg::WIN_W:0]   diff;
   logic                      fit;

   always_comb begin
      shifted = {rem_ff, quo_ff[mal_pkg::SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fit     = shifted >= {1'b0, dvs_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = mal_pkg::CNT_W'(mal_pkg::SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mal_pkg::SUM_W-2:0], fit};
         rem_in = fit ? diff[mal_pkg::WIN_W-1:0] : shifted[mal_pkg::WIN_W-1:0];
         cnt_in = cnt_ff - mal_pkg::CNT_W'(1);
         if (cnt_ff == mal_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

/* rtl/core/mal_datapath.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass datapath
// History ring, running window sum, divider, window register, output buffer.
// ----------------------------------------------------------------------------
`include "moving_average_lowpass_defines.svh"

module mal_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mal_pkg::cmd_type                    cmd,
   output mal_pkg::status_type                 status,
   input  logic signed [mal_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_clear_ring,
   input  logic                                csr_valid,
   input  logic [mal_pkg::WINDOW_W-1:0]        csr_window_length,
   output logic                                csr_ready,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [mal_pkg::SAMPLE_W-1:0] rsp_filtered_sample
);
   localparam int SW = mal_pkg::SAMPLE_W;
   localparam int CW = mal_pkg::CMP_W;

   // configuration and control state
   logic [mal_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic                            dirty_ff, dirty_in;
   logic [mal_pkg::ROWS-1:0]        row_valid_ff, row_valid_in;
   logic [mal_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic signed [mal_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [mal_pkg::ROW_W-1:0]       scan_row_ff, scan_row_in;
   logic                            stale_ff, stale_in;
   logic                            mode_ff, mode_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [SW-1:0]            sample_ff;
   logic                            neg_ff;
   logic [SW-1:0]                   res_ff, res_in;
   logic [SW-1:0]                   rsp_data_ff;
   logic [mal_pkg::ROW_W-1:0]       rd_row_ff;
   logic                            rd_valid_ff;

   logic [mal_pkg::WIN_W-1:0]       win;
   logic [mal_pkg::WIN_W-1:0]       idx_p1;
   logic [mal_pkg::ROW_W-1:0]       idx_row;
   logic [mal_pkg::LANE_W-1:0]      idx_lane;
   logic [mal_pkg::ROW_W-1:0]       last_row;
   logic [mal_pkg::ROW_W-1:0]       rd_row;
   logic                            rd_en;
   logic [mal_pkg::ROW_DATA_W-1:0]  ram_q;
   logic [mal_pkg::ROW_DATA_W-1:0]  row_q;
   logic [mal_pkg::ROW_DATA_W-1:0]  new_row;
   logic signed [SW-1:0]            lane_val [mal_pkg::LANES];
   logic signed [SW-1:0]            old_val;
   logic signed [mal_pkg::SUM_W-1:0] scan_sum;
   logic [mal_pkg::ROW_W+mal_pkg::LANE_W-1:0] gidx;
   logic [mal_pkg::SUM_W-1:0]       acc_abs;
   logic [mal_pkg::SUM_W-1:0]       q_signed;
   logic                            div_start;
   logic [mal_pkg::SUM_W-1:0]       div_dividend;
   logic                            div_busy;
   logic                            div_done;
   logic [mal_pkg::SUM_W-1:0]       div_quo;
   logic [mal_pkg::WIN_W-1:0]       div_rem;

   // zero acts as one, saturate at the ring size
   always_comb begin
      if (window_ff == '0) begin
         win = mal_pkg::WIN_W'(1);
      end else if (CW'(window_ff) > CW'(mal_pkg::RING_DEPTH)) begin
         win = mal_pkg::WIN_W'(mal_pkg::RING_DEPTH);
      end else begin
         win = mal_pkg::WIN_W'(window_ff);
      end
   end

   assign idx_p1   = mal_pkg::WIN_W'(idx_ff) + mal_pkg::WIN_W'(1);
   assign idx_row  = mal_pkg::ROW_W'(idx_ff / mal_pkg::LANES);
   assign idx_lane = mal_pkg::LANE_W'(idx_ff % mal_pkg::LANES);
   assign last_row = mal_pkg::ROW_W'((win - mal_pkg::WIN_W'(1)) / mal_pkg::LANES);

   // ring memory, read-modify-write per sample
   assign rd_en  = cmd.scan_rd | cmd.rd_old;
   assign rd_row = cmd.scan_rd ? scan_row_ff : idx_row;

   mal_ram #(
      .WIDTH (mal_pkg::ROW_DATA_W),
      .DEPTH (mal_pkg::ROWS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (idx_row),
      .wr_data (new_row),
      .rd_en   (rd_en),
      .rd_addr (rd_row),
      .rd_data (ram_q)
   );

   // rows not written since the last clear read as zero
   assign row_q = rd_valid_ff ? ram_q : '0;

   always_comb begin
      for (int l = 0; l < mal_pkg::LANES; l++) begin
         lane_val[l] = row_q[l*SW +: SW];
         new_row[l*SW +: SW] = (idx_lane == mal_pkg::LANE_W'(l)) ? sample_ff : lane_val[l];
      end
      old_val = lane_val[idx_lane];
   end

   always_comb begin
      scan_sum = '0;
      gidx     = '0;
      for (int l = 0; l < mal_pkg::LANES; l++) begin
         gidx = {rd_row_ff, mal_pkg::LANE_W'(l)};
         if (CW'(gidx) < CW'(win)) begin
            scan_sum = scan_sum + mal_pkg::SUM_W'(lane_val[l]);
         end
      end
   end

   always_comb begin
      acc_abs  = acc_ff[mal_pkg::SUM_W-1] ? mal_pkg::SUM_W'(-acc_ff)
                                          : mal_pkg::SUM_W'(acc_ff);
      q_signed = neg_ff ? -div_quo : div_quo;
   end

   assign div_start    = cmd.div_go | cmd.mod_go;
   assign div_dividend = cmd.mod_go ? mal_pkg::SUM_W'(idx_p1) : acc_abs;

   mal_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (win),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      window_in    = window_ff;
      dirty_in     = dirty_ff;
      row_valid_in = row_valid_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      scan_row_in  = scan_row_ff;
      stale_in     = stale_ff;
      mode_in      = mode_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_valid) begin
         window_in = csr_window_length;
         dirty_in  = 1'b1;
      end

      if (cmd.accept) begin
         dirty_in    = 1'b0;
         scan_row_in = '0;
         // a clear or a rescan both start from an empty sum
         if (req_clear_ring || dirty_ff) begin
            acc_in = '0;
         end
         if (req_clear_ring) begin
            row_valid_in = '0;
            idx_in       = '0;
         end
      end

      if (cmd.scan_acc) begin
         acc_in      = acc_ff + scan_sum;
         scan_row_in = scan_row_ff + mal_pkg::ROW_W'(1);
      end

      if (cmd.write) begin
         row_valid_in[idx_row] = 1'b1;
         if (CW'(idx_ff) < CW'(win)) begin
            acc_in = acc_ff + mal_pkg::SUM_W'(sample_ff) - mal_pkg::SUM_W'(old_val);
         end
         stale_in = idx_p1 > win;
         if (idx_p1 == win) begin
            idx_in = '0;
         end else if (idx_p1 < win) begin
            idx_in = mal_pkg::IDX_W'(idx_p1);
         end
      end

      if (div_start) begin
         mode_in = cmd.mod_go;
      end

      if (div_done) begin
         if (mode_ff) begin
            idx_in = mal_pkg::IDX_W'(div_rem);
         end else begin
            res_in = q_signed[SW-1:0];
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= mal_pkg::WINDOW_W'(1);
         dirty_ff     <= 1'b0;
         row_valid_ff <= '0;
         idx_ff       <= '0;
         acc_ff       <= '0;
         scan_row_ff  <= '0;
         stale_ff     <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         dirty_ff     <= dirty_in;
         row_valid_ff <= row_valid_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         scan_row_ff  <= scan_row_in;
         stale_ff     <= stale_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (rd_en) begin
         rd_row_ff   <= rd_row;
         rd_valid_ff <= row_valid_ff[rd_row];
      end
      if (cmd.div_go) begin
         neg_ff <= acc_ff[mal_pkg::SUM_W-1];
      end
      res_ff <= res_in;
      if (cmd.load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign status.need_scan = dirty_ff & ~req_clear_ring;
   assign status.scan_last = rd_row_ff == last_row;
   assign status.stale     = stale_ff;
   assign status.div_done  = div_done;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_data_ff;

   `MAL_ASSERT(a_div_idle_on_start, clock, reset, !(div_start && div_busy))
   `MAL_ASSERT_NEXT(a_clear_empties_sum, clock, reset, cmd.accept && req_clear_ring,
                    acc_ff == '0 && idx_ff == '0)
   `MAL_ASSERT_NEXT(a_index_in_window, clock, reset, cmd.write,
                    stale_ff || CW'(idx_ff) < CW'(win))
endmodule

/* rtl/core/mal_ctrl.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass controller
// Sequences rescan, ring update, divide and result hand-off per sample.
// ----------------------------------------------------------------------------
`include "moving_average_lowpass_defines.svh"

module mal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mal_pkg::status_type  status,
   output mal_pkg::cmd_type     cmd
);
   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_SCAN_RD  = 10'b0000000010,
      S_SCAN_ACC = 10'b0000000100,
      S_RD_OLD   = 10'b0000001000,
      S_WRITE    = 10'b0000010000,
      S_DIV_GO   = 10'b0000100000,
      S_DIV_WAIT = 10'b0001000000,
      S_MOD_GO   = 10'b0010000000,
      S_MOD_WAIT = 10'b0100000000,
      S_OUT      = 10'b1000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.need_scan ? S_SCAN_RD : S_RD_OLD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_ACC;
         end
         S_SCAN_ACC: begin
            cmd.scan_acc = 1'b1;
            state_in     = status.scan_last ? S_RD_OLD : S_SCAN_RD;
         end
         S_RD_OLD: begin
            cmd.rd_old = 1'b1;
            state_in   = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = status.stale ? S_MOD_GO : S_OUT;
            end
         end
         S_MOD_GO: begin
            cmd.mod_go = 1'b1;
            state_in   = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // output buffer takes the result once the previous one has gone
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   `MAL_ASSERT_NEXT(a_accept_starts_work, clock, reset, cmd.accept,
                    state_ff == S_SCAN_RD || state_ff == S_RD_OLD)
   `MAL_ASSERT_NEXT(a_write_then_divide, clock, reset, state_ff == S_WRITE,
                    state_ff == S_DIV_GO)
   `MAL_ASSERT(a_done_only_when_waiting, clock, reset,
               !status.div_done || state_ff == S_DIV_WAIT || state_ff == S_MOD_WAIT)
endmodule

/* rtl/core/moving_average_lowpass.sv */
// ----------------------------------------------------------------------------
// Moving average low-pass filter
// Box filter over a ring of signed 16-bit samples, averaged by window length.
// ----------------------------------------------------------------------------
//   channel  | direction | payload                        | accepted when
//   req_ch   | in        | sample, clear_ring             | valid && ready
//   rsp_ch   | out       | filtered_sample                | valid && ready
//   csr_ch   | in        | window_length                  | valid && ready
//
// One sample at a time: each sample waits on the restoring divider, and a
// stale write index adds a second divide. The first sample after a window
// write rescans the ring, reading then summing each row of 4 samples.
// Reset is synchronous; the ring needs no clearing pass as per-row valid
// bits are cleared at once. A waiting result sits in the output register
// while the next sample is taken in.
// ----------------------------------------------------------------------------
module moving_average_lowpass (
   input  logic          clock,
   input  logic          reset,
   mal_req_if.sink       req_ch,
   mal_rsp_if.source     rsp_ch,
   mal_csr_if.sink       csr_ch
);
   mal_pkg::cmd_type    cmd;
   mal_pkg::status_type status;
   logic                req_ready;
   logic                csr_ready;
   logic                rsp_valid;
   logic signed [mal_pkg::SAMPLE_W-1:0] rsp_filtered_sample;

   mal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mal_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample          (req_ch.sample),
      .req_clear_ring      (req_ch.clear_ring),
      .csr_valid           (csr_ch.valid),
      .csr_window_length   (csr_ch.window_length),
      .csr_ready           (csr_ready),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_valid),
      .rsp_filtered_sample (rsp_filtered_sample)
   );

   assign req_ch.ready           = req_ready;
   assign csr_ch.ready           = csr_ready;
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.filtered_sample = rsp_filtered_sample;
endmodule
